// ----- sv/bciu_pkg.sv -----
// Shared types, opcodes and constants for the bytecode integer execute unit.
`timescale 1ns / 1ps
package bciu_pkg;

    localparam int REG_COUNT_DEF = 256;

    // fault codes
    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_DIV_ZERO = 2'd1;
    localparam logic [1:0] FAULT_DIV_OVF  = 2'd2;
    localparam logic [1:0] FAULT_BAD_OP   = 2'd3;

    // opcodes and opcode bounds
    localparam logic [7:0] OP_ALU_LAST  = 8'h1D;
    localparam logic [7:0] OP_IMM_LAST  = 8'h15;
    localparam logic [7:0] OP_SHL_IMM   = 8'h19;
    localparam logic [7:0] OP_SRA_IMM   = 8'h1B;
    localparam logic [7:0] OP_SHR_IMM   = 8'h1D;
    localparam logic [7:0] OP_NOT       = 8'h16;
    localparam logic [7:0] OP_NADD_LO   = 8'h30;
    localparam logic [7:0] OP_NSUB_LO   = 8'h32;
    localparam logic [7:0] OP_NAT_HI    = 8'h33;
    localparam logic [7:0] OP_JMP       = 8'h60;
    localparam logic [7:0] OP_JN        = 8'h61;
    localparam logic [7:0] OP_JNN       = 8'h62;
    localparam logic [7:0] OP_BR_LO     = 8'h70;
    localparam logic [7:0] OP_BR_HI     = 8'h7F;
    localparam logic [7:0] OP_MOV       = 8'hC0;
    localparam logic [7:0] OP_MOV_WIDE  = 8'hC1;
    localparam logic [7:0] OP_MOV_NAT   = 8'hC3;
    localparam logic [7:0] OP_LDI       = 8'hC4;
    localparam logic [7:0] OP_LDI_WIDE  = 8'hC5;
    localparam logic [7:0] OP_LDI_NAT   = 8'hC6;
    localparam logic [7:0] OP_LDI_WIDE2 = 8'hC7;
    localparam logic [7:0] OP_CLR       = 8'hCB;

    // ALU groups, opcode with the immediate bit cleared
    localparam logic [7:0] ALU_ADD  = 8'h00;
    localparam logic [7:0] ALU_SUB  = 8'h02;
    localparam logic [7:0] ALU_MUL  = 8'h04;
    localparam logic [7:0] ALU_MULU = 8'h06;
    localparam logic [7:0] ALU_DIVI = 8'h08;
    localparam logic [7:0] ALU_DIVU = 8'h0A;
    localparam logic [7:0] ALU_REMI = 8'h0C;
    localparam logic [7:0] ALU_REMU = 8'h0E;
    localparam logic [7:0] ALU_AND  = 8'h10;
    localparam logic [7:0] ALU_OR   = 8'h12;
    localparam logic [7:0] ALU_XOR  = 8'h14;
    localparam logic [7:0] ALU_NEG  = 8'h16;
    localparam logic [7:0] ALU_SHL  = 8'h18;
    localparam logic [7:0] ALU_SRA  = 8'h1A;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic        signed_op;
        logic        want_rem;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;

endpackage

// ----- sv/bytecode_integer_execute_unit.sv -----
// Top level: sequencer, register file, ALU and branch logic of the execute unit.
// Each instruction steps through read, execute and result states; divide/remainder adds a divide state.
// Throughput: one instruction at a time; a new request is taken only after the previous result
// has been accepted; the 32-step divider sets the worst case.
// After reset a clearing pass over all REGISTER_COUNT entries zeroes the register file.
// Reset (rst_n, asynchronous, active low) also clears the pc and all control state.
`timescale 1ns / 1ps
module bytecode_integer_execute_unit
    import bciu_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[7:0], reg_a[15:8], reg_b[23:16], reg_c[31:24], imm_low[63:32], imm_high[95:64]
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0], write_enable[32], write_wide[33], write_index[41:34],
    // write_value[105:42], fault[107:106], zero fill to 111
    output logic [111:0] m_tdata
);

    localparam int IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [IW:0] clr_reg;
    logic [31:0] pc_reg;
    logic [7:0]  op_reg;
    logic [IW-1:0] ia_reg, ib_reg;
    logic [31:0] il_reg, ih_reg;
    logic [63:0] ra_reg, rb_reg, rc_reg;
    logic [111:0] out_reg;
    logic        m_valid_reg;

    logic [63:0] rf [REGISTER_COUNT];

    // register file, registered reads on two ports, one write port;
    // reg_c is fetched straight from the request at acceptance
    logic          rf_we;
    logic [IW-1:0] rf_wa;
    logic [63:0]   rf_wd;

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_wa] <= rf_wd;
        ra_reg <= rf[ia_reg];
        if (state_reg == ST_IDLE)
            rc_reg <= rf[s_tdata[IW-1+24:24]];
        else
            rb_reg <= rf[ib_reg];
    end

    // execute
    div_req_t dreq;
    div_rsp_t drsp;
    bciu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic        alu_imm, is_alu, we, wide, taken, is_div;
    logic [7:0]  grp;
    logic [31:0] a32, b32, c32, y, r, pc1, nxt;
    logic [63:0] val;
    logic [1:0]  flt;
    logic signed [31:0] sa, sb;

    always_comb
    begin
        a32 = ra_reg[31:0];
        b32 = rb_reg[31:0];
        c32 = rc_reg[31:0];
        sa = a32;
        sb = b32;
        pc1 = pc_reg + 32'd1;
        nxt = pc1;
        we = 1'b0;
        wide = 1'b0;
        val = 64'd0;
        flt = FAULT_OK;
        taken = 1'b0;
        is_div = 1'b0;
        r = 32'd0;
        is_alu = op_reg <= OP_ALU_LAST;
        alu_imm = (op_reg <= OP_IMM_LAST) ? op_reg[0]
                : (op_reg == OP_SHL_IMM || op_reg == OP_SRA_IMM || op_reg == OP_SHR_IMM);
        y = alu_imm ? il_reg : c32;
        grp = {op_reg[7:1], 1'b0};
        if (is_alu)
        begin
            if (alu_imm)
                nxt = pc1 + 32'd1;
            we = 1'b1;
            case (grp)
                ALU_ADD:  r = b32 + y;
                ALU_SUB:  r = b32 - y;
                ALU_MUL, ALU_MULU: r = b32 * y;
                ALU_DIVI, ALU_REMI:
                begin
                    if (y == 32'd0)
                    begin
                        flt = FAULT_DIV_ZERO;
                        we = 1'b0;
                    end
                    else if (b32 == 32'h8000_0000 && y == 32'hFFFF_FFFF)
                    begin
                        flt = FAULT_DIV_OVF;
                        we = 1'b0;
                    end
                    else
                        is_div = 1'b1;
                end
                ALU_DIVU, ALU_REMU:
                begin
                    if (y == 32'd0)
                    begin
                        flt = FAULT_DIV_ZERO;
                        we = 1'b0;
                    end
                    else
                        is_div = 1'b1;
                end
                ALU_AND: r = b32 & y;
                ALU_OR:  r = b32 | y;
                ALU_XOR: r = b32 ^ y;
                ALU_NEG: r = (op_reg == OP_NOT) ? ~b32 : 32'd0 - b32;
                ALU_SHL: r = b32 << y[4:0];
                ALU_SRA: r = $unsigned(sb >>> y[4:0]);
                default: r = b32 >> y[4:0];
            endcase
            val = {32'd0, r};
        end
        else if (op_reg >= OP_NADD_LO && op_reg <= OP_NAT_HI)
        begin
            we = 1'b1;
            val = {32'd0, (op_reg < OP_NSUB_LO) ? b32 + c32 : b32 - c32};
        end
        else if (op_reg >= OP_JMP && op_reg <= OP_JNN)
        begin
            taken = (op_reg == OP_JMP) || ((op_reg == OP_JN) == (a32 == 32'd0));
            nxt = taken ? pc1 + il_reg : pc1 + 32'd1;
        end
        else if (op_reg >= OP_BR_LO && op_reg <= OP_BR_HI)
        begin
            case (op_reg[3:0])
                4'h0: taken = sa == 0;
                4'h1: taken = sa != 0;
                4'h2: taken = sa > 0;
                4'h3: taken = sa >= 0;
                4'h4: taken = sa < 0;
                4'h5: taken = sa <= 0;
                4'h6: taken = a32 == b32;
                4'h7: taken = a32 != b32;
                4'h8: taken = sa > sb;
                4'h9: taken = a32 > b32;
                4'hA: taken = sa >= sb;
                4'hB: taken = a32 >= b32;
                4'hC: taken = sa < sb;
                4'hD: taken = a32 < b32;
                4'hE: taken = sa <= sb;
                default: taken = a32 <= b32;
            endcase
            nxt = taken ? pc1 + il_reg : pc1 + 32'd1;
        end
        else
        begin
            case (op_reg)
                OP_MOV, OP_MOV_NAT:
                begin
                    we = 1'b1;
                    val = {32'd0, b32};
                end
                OP_MOV_WIDE:
                begin
                    we = 1'b1;
                    wide = 1'b1;
                    val = rb_reg;
                end
                OP_LDI, OP_LDI_NAT:
                begin
                    we = 1'b1;
                    val = {32'd0, il_reg};
                    nxt = pc1 + 32'd1;
                end
                OP_LDI_WIDE, OP_LDI_WIDE2:
                begin
                    we = 1'b1;
                    wide = 1'b1;
                    val = {ih_reg, il_reg};
                    nxt = pc1 + 32'd2;
                end
                OP_CLR: we = 1'b1;
                default: flt = FAULT_BAD_OP;
            endcase
        end
        dreq.start = (state_reg == ST_EXEC) && is_div;
        dreq.signed_op = !op_reg[1];
        dreq.want_rem = op_reg[2];
        dreq.dividend = b32;
        dreq.divisor = y;
    end

    // sequencer
    logic [111:0] out_next;
    logic [31:0]  pc_next;
    always_comb
    begin
        state_next = state_reg;
        out_next = out_reg;
        pc_next = pc_reg;
        rf_we = 1'b0;
        rf_wa = ia_reg;
        rf_wd = wide ? val : {ra_reg[63:32], val[31:0]};
        case (state_reg)
            ST_CLEAR:
            begin
                rf_we = 1'b1;
                rf_wa = clr_reg[IW-1:0];
                rf_wd = 64'd0;
                if (clr_reg == (IW+1)'(REGISTER_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                pc_next = nxt;
                if (is_div)
                    state_next = ST_DIV;
                else
                begin
                    rf_we = we;
                    out_next = {4'd0, flt, we ? val : 64'd0,
                                we ? 8'(ia_reg) : 8'd0, we & wide, we, nxt};
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
                if (drsp.done)
                begin
                    rf_we = 1'b1;
                    rf_wd = {ra_reg[63:32], drsp.result};
                    out_next = {4'd0, FAULT_OK, 32'd0, drsp.result,
                                8'(ia_reg), 1'b0, 1'b1, pc_reg};
                    state_next = ST_OUT;
                end
            ST_OUT:
                if (m_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            pc_reg <= 32'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            m_valid_reg <= (state_next == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            op_reg <= s_tdata[7:0];
            ia_reg <= s_tdata[IW-1+8:8];
            ib_reg <= s_tdata[IW-1+16:16];
            il_reg <= s_tdata[63:32];
            ih_reg <= s_tdata[95:64];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == ST_DIV) else $error("divider done outside divide");
    a_fault_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[107:106] != FAULT_OK) |-> !m_tdata[32])
        else $error("faulting request wrote a register");
`endif

endmodule

// ----- sv/bciu_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bciu_div
    import bciu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        rem_sel_reg, rem_sel_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;
    logic [31:0] mag_a, mag_b;

    always_comb
    begin
        mag_a = (req.signed_op && req.dividend[31]) ? 32'd0 - req.dividend : req.dividend;
        mag_b = (req.signed_op && req.divisor[31]) ? 32'd0 - req.divisor : req.divisor;
        // partial remainder can reach 33 bits before the subtract
        shifted = {rem_reg, quo_reg[31]};
        trial = {1'b0, shifted} - {2'b00, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        rem_sel_next = rem_sel_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = 32'd0;
            quo_next = mag_a;
            dsr_next = mag_b;
            cnt_next = 6'd32;
            busy_next = 1'b1;
            neg_q_next = req.signed_op && (req.dividend[31] ^ req.divisor[31]);
            neg_r_next = req.signed_op && req.dividend[31];
            rem_sel_next = req.want_rem;
        end
        else if (busy_reg)
        begin
            // one quotient bit per step
            rem_next = trial[33] ? shifted[31:0] : trial[31:0];
            quo_next = {quo_reg[30:0], ~trial[33]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        rem_sel_reg <= rem_sel_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (rem_sel_reg)
            rsp.result = neg_r_reg ? 32'd0 - rem_reg : rem_reg;
        else
            rsp.result = neg_q_reg ? 32'd0 - quo_reg : quo_reg;
    end

endmodule
